// ----- hw/rtl/sba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_pkg: shared types and constants of the sector bitmap allocator
// Field widths, operation and status codes, controller state type and the
// command and status groups exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package sba_pkg;

	localparam int TRACKS_DEF      = 35;
	localparam int FIRST_ALLOC_DEF = 1;

	localparam int OP_W      = 2;
	localparam int STATUS_W  = 2;
	localparam int TRACK_W   = 6;
	localparam int SECTOR_W  = 4;
	localparam int WORD_W    = 16;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 32;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_READ  = 2'd2
	} sba_op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_RANGE = 2'd2
	} sba_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_READ,
		ST_RESOLVE
	} sba_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic search;
		logic read;
		logic commit;
	} sba_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic out_free;
	} sba_sts_t;

endpackage

// ----- hw/rtl/sba_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_ctrl: sequencing state machine of the sector bitmap allocator
// Steps one request through search, map read and resolve, and hands the
// result to the output register once it is free.
// ----------------------------------------------------------------------------
module sba_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output sba_pkg::sba_cmd_t cmd,
	input  sba_pkg::sba_sts_t sts
);
	import sba_pkg::*;

	sba_state_t state_q;
	sba_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				state_nxt = ST_READ;
			end
			ST_READ: begin
				state_nxt = ST_RESOLVE;
			end
			ST_RESOLVE: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.search  = 1'b0;
		cmd.read    = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
			end
			ST_READ: begin
				cmd.read = 1'b1;
			end
			ST_RESOLVE: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

// ----- hw/rtl/sba_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_dp: datapath of the sector bitmap allocator
// Holds the used-sector map, the per-track full summary, the track and
// sector first-fit pickers and the output register.
// ----------------------------------------------------------------------------
module sba_dp #(
	parameter int TRACKS            = sba_pkg::TRACKS_DEF,
	parameter int FIRST_ALLOC_TRACK = sba_pkg::FIRST_ALLOC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sba_pkg::sba_cmd_t             cmd,
	output sba_pkg::sba_sts_t             sts,
	input  logic [sba_pkg::OP_W-1:0]      in_op,
	input  logic [sba_pkg::TRACK_W-1:0]   in_track,
	input  logic [sba_pkg::WORD_W-1:0]    in_word,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sba_pkg::STATUS_W-1:0]  out_status,
	output logic [sba_pkg::TRACK_W-1:0]   out_track,
	output logic [sba_pkg::SECTOR_W-1:0]  out_sector,
	output logic [sba_pkg::WORD_W-1:0]    out_word
);
	import sba_pkg::*;

	localparam int TIDX_W = $clog2(TRACKS);
	localparam logic [TRACKS-1:0] ALLOC_MASK = {TRACKS{1'b1}} << FIRST_ALLOC_TRACK;

	// Request registers.
	sba_op_t             op_q;
	logic [TRACK_W-1:0]  trk_q;
	logic [WORD_W-1:0]   word_q;

	// Map storage; entries not yet written read as all free.
	logic [WORD_W-1:0]   used_mem [TRACKS];
	logic [TRACKS-1:0]   vld_q;
	logic [TRACKS-1:0]   full_q;

	logic [TRACKS-1:0]   cand;
	logic [TRACKS-1:0]   cand_oh;
	logic [TIDX_W-1:0]   cand_idx;
	logic [TIDX_W-1:0]   srch_idx_q;
	logic                srch_found_q;

	logic                in_range;
	logic [TIDX_W-1:0]   rd_addr;
	logic [WORD_W-1:0]   rd_data_q;
	logic                rd_vld_q;

	logic [WORD_W-1:0]   used_eff;
	logic [WORD_W-1:0]   free_eff;
	logic [WORD_W-1:0]   sec_oh;
	logic [SECTOR_W-1:0] sec_idx;

	logic                wr_en;
	logic [TIDX_W-1:0]   wr_addr;
	logic [WORD_W-1:0]   wr_data;

	sba_status_t         res_status;
	logic [TRACK_W-1:0]  res_track;
	logic [SECTOR_W-1:0] res_sector;
	logic [WORD_W-1:0]   res_word;

	logic                m_tvalid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [TRACK_W-1:0]  out_track_q;
	logic [SECTOR_W-1:0] out_sector_q;
	logic [WORD_W-1:0]   out_word_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= sba_op_t'(in_op);
			trk_q  <= in_track;
			word_q <= in_word;
		end
	end

	assign in_range = {1'b0, trk_q} < (TRACK_W + 1)'(TRACKS);

	// First track at or above the allocation floor that still has a free sector.
	assign cand    = ~full_q & ALLOC_MASK;
	assign cand_oh = cand & (~cand + TRACKS'(1));

	always_comb begin
		cand_idx = '0;
		for (int i = 0; i < TRACKS; i++) begin
			if (cand_oh[i]) begin
				cand_idx = cand_idx | TIDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.search) begin
			srch_idx_q   <= cand_idx;
			srch_found_q <= |cand;
		end
	end

	assign rd_addr = (op_q == OP_ALLOC) ? srch_idx_q : trk_q[TIDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rd_data_q <= used_mem[rd_addr];
			rd_vld_q  <= vld_q[rd_addr];
		end
	end

	// First free sector of the track just read.
	assign used_eff = rd_vld_q ? rd_data_q : '0;
	assign free_eff = ~used_eff;
	assign sec_oh   = free_eff & (~free_eff + WORD_W'(1));

	always_comb begin
		sec_idx = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (sec_oh[i]) begin
				sec_idx = sec_idx | SECTOR_W'(i);
			end
		end
	end

	always_comb begin
		res_status = STS_OK;
		res_track  = '0;
		res_sector = '0;
		res_word   = '0;
		wr_en      = 1'b0;
		wr_addr    = trk_q[TIDX_W-1:0];
		wr_data    = ~word_q;
		unique case (op_q)
			OP_LOAD: begin
				if (in_range) begin
					wr_en = 1'b1;
				end else begin
					res_status = STS_RANGE;
				end
			end
			OP_READ: begin
				if (in_range) begin
					res_word = free_eff;
				end else begin
					res_status = STS_RANGE;
				end
			end
			OP_ALLOC: begin
				wr_addr = srch_idx_q;
				wr_data = used_eff | sec_oh;
				if (srch_found_q) begin
					wr_en      = 1'b1;
					res_track  = TRACK_W'(srch_idx_q);
					res_sector = sec_idx;
				end else begin
					res_status = STS_FULL;
				end
			end
			default: begin
				res_status = STS_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			used_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			full_q <= '0;
		end else if (cmd.commit && wr_en) begin
			vld_q[wr_addr]  <= 1'b1;
			full_q[wr_addr] <= &wr_data;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status_q <= res_status;
			out_track_q  <= res_track;
			out_sector_q <= res_sector;
			out_word_q   <= res_word;
		end
	end

	assign sts.out_free = !m_tvalid_q || m_tready;
	assign m_tvalid     = m_tvalid_q;
	assign out_status   = out_status_q;
	assign out_track    = out_track_q;
	assign out_sector   = out_sector_q;
	assign out_word     = out_word_q;

endmodule

// ----- hw/rtl/sector_bitmap_allocator.sv -----
`timescale 1ns / 1ps
// Each request word steps through the search, map read and resolve steps, and
// its result is loaded into the output register; a new request word is taken
// only once the previous one has been resolved.
// Reset: arst_n clears the controller, the output valid and the map valid and
// full bits at once, so every sector reads as free right after reset.
// ----------------------------------------------------------------------------
// sector_bitmap_allocator: first-fit free-sector allocator for a floppy volume
// Keeps a 16-sector used map per track. Load writes a track's free word, read
// returns it, and allocate marks the first free sector from the allocation
// floor track upward and reports its track and sector.
// ----------------------------------------------------------------------------
module sector_bitmap_allocator #(
	parameter int TRACKS            = sba_pkg::TRACKS_DEF,
	parameter int FIRST_ALLOC_TRACK = sba_pkg::FIRST_ALLOC_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request channel.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// tdata: track_index [5:0], free_word_in [21:6], zero [23:22].
	input  logic [sba_pkg::S_TDATA_W-1:0]  s_tdata,
	// tuser: command [1:0].
	input  logic [sba_pkg::OP_W-1:0]       s_tuser,
	// Result channel.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// tdata: alloc_track [5:0], alloc_sector [9:6], free_word_out [25:10],
	// zero [31:26].
	output logic [sba_pkg::M_TDATA_W-1:0]  m_tdata,
	// tuser: status [1:0].
	output logic [sba_pkg::STATUS_W-1:0]   m_tuser
);
	import sba_pkg::*;

	sba_cmd_t            cmd;
	sba_sts_t            sts;
	logic [TRACK_W-1:0]  out_track;
	logic [SECTOR_W-1:0] out_sector;
	logic [WORD_W-1:0]   out_word;

	// The controller only takes a new request word once the previous one has
	// been resolved; a finished result may still wait in the output register
	// while the next request is accepted.
	sba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// For an allocate the datapath searches the full summary for the first track
	// with space, reads that track's map entry, picks the lowest free sector and
	// writes the updated entry back while loading the output register.
	sba_dp #(
		.TRACKS            (TRACKS),
		.FIRST_ALLOC_TRACK (FIRST_ALLOC_TRACK)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_op      (s_tuser),
		.in_track   (s_tdata[TRACK_W-1:0]),
		.in_word    (s_tdata[TRACK_W +: WORD_W]),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.out_status (m_tuser),
		.out_track  (out_track),
		.out_sector (out_sector),
		.out_word   (out_word)
	);

	assign m_tdata = {{(M_TDATA_W - TRACK_W - SECTOR_W - WORD_W){1'b0}},
		out_word, out_sector, out_track};

endmodule
